@@ rtl/rrga_pkg.sv @@
// ----------------------------------------------------------------------------
// rrga_pkg
// shared constants and types of the range gate autocorrelator
// ----------------------------------------------------------------------------
package rrga_pkg;

    localparam int MAX_GATES  = 512;
    localparam int CHANNELS   = 2;
    localparam int GATE_W     = $clog2(MAX_GATES);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W      = CH_W + GATE_W;
    localparam int DEPTH      = CHANNELS * MAX_GATES;

    localparam logic [9:0]  GATES_RESET = 10'd500;
    localparam logic [9:0]  FRAME_RESET = 10'd800;
    localparam logic [23:0] SUM_MAX     = 24'hFFFFFF;
    localparam logic [43:0] CORR_MAX    = 44'hFFFFFFFFFFF;

    localparam logic [0:0] REG_GATES = 1'b0;
    localparam logic [0:0] REG_FRAME = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [15:0]      mean;
        logic             add_prod;
        logic             last_pulse;
        logic             ch;
        logic [8:0]       gate;
    } t_close;

endpackage

@@ rtl/radar_range_gate_autocorrelator_top.sv @@
// ----------------------------------------------------------------------------
// radar_range_gate_autocorrelator_top
// magnitude, range gating and per gate lag-one autocorrelation
// ----------------------------------------------------------------------------
// One sample is taken per request and processed to completion before the next
// is accepted. A sample that closes no gate is accepted, passes the square root
// (one root bit per cycle) and is accumulated. A first-of-pulse sample first
// runs the step division. A closing gate adds the mean division (unless its
// quota is zero), reads the gate memories, updates and writes them back and
// loads the output register. On a frame's last pulse the frame division comes
// between write back and output. All divisions share one serial divider. A
// closing gate also waits while the previous result is still held in the
// output register.
// Gate state lives in two 1024 entry memories (previous mean, correlation sum).
// After reset a clearing pass runs over all 1024 entries, one entry per cycle,
// before the first sample is accepted. Results leave through an output
// register, so the next sample may enter while a result waits.
module radar_range_gate_autocorrelator_top
    import rrga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pulse_samples[12:0], in_phase[28:13], quadrature[44:29], zero fill
    input  logic [47:0] s_axis_tdata,
    // tuser: channel[0], first_of_pulse[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: gate_number[8:0], gate_mean[24:9], autocorrelation[58:25], zero fill
    output logic [63:0] m_axis_tdata,
    // tuser: out_channel[0], autocorrelation_valid[1]
    output logic [1:0]  m_axis_tuser
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_STEP, S_SQRT, S_ACC, S_MEAN, S_RD, S_UPD, S_FRM, S_OUT
    } t_state;

    t_state r_state;
    logic [9:0]  r_gates_cfg, r_frame_cfg;
    logic [9:0]  w_gates;
    logic [9:0]  w_frame;
    logic [23:0] r_gsum;
    logic [12:0] r_fill, r_quota;
    logic [15:0] r_frac;
    logic [28:0] r_step;
    logic [9:0]  r_cur;
    logic [9:0]  r_pc [CHANNELS];
    logic [IDX_W-1:0] r_clr;
    logic        r_ch;
    logic [15:0] r_i, r_q;
    logic [31:0] r_rad, r_root;
    logic [4:0]  r_it;
    t_close      r_cl;
    logic [15:0] r_pm_rd;
    logic [43:0] r_cs_rd;
    logic [43:0] w_csnew;
    logic        r_dstart;
    logic [43:0] r_dnum;
    logic [28:0] r_dden;
    logic        w_ddone;
    logic [43:0] w_dquo;
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic [1:0]  r_ouser;

    logic [15:0] pm_mem [DEPTH];
    logic [43:0] cs_mem [DEPTH];
    logic        w_we;
    logic [IDX_W-1:0] w_wa;
    logic [15:0] w_pm_wd;
    logic [43:0] w_cs_wd;

    assign w_gates = (r_gates_cfg == 10'd0) ? 10'd1 :
                     (r_gates_cfg > 10'(MAX_GATES)) ? 10'(MAX_GATES) : r_gates_cfg;
    assign w_frame = (r_frame_cfg < 10'd2) ? 10'd2 : r_frame_cfg;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_GATES: prdata = {22'd0, r_gates_cfg};
            REG_FRAME: prdata = {22'd0, r_frame_cfg};
            default:   prdata = '0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gates_cfg <= GATES_RESET;
            r_frame_cfg <= FRAME_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_GATES: r_gates_cfg <= pwdata[9:0];
                REG_FRAME: r_frame_cfg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    rrga_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_dnum),
        .i_den(r_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    // memories: one write port, registered reads at the closing index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            pm_mem[w_wa] <= w_pm_wd;
            cs_mem[w_wa] <= w_cs_wd;
        end
        r_pm_rd <= pm_mem[r_cl.idx];
        r_cs_rd <= cs_mem[r_cl.idx];
    end

    logic [9:0]  w_pcn;
    logic [31:0] w_mag;
    logic [24:0] w_gs;
    logic [31:0] w_prod;
    logic [44:0] w_csum;
    logic [28:0] w_t;
    logic [15:0] w_ai, w_aq;
    logic [31:0] w_sq;

    assign w_we    = (r_state == S_CLEAR) || (r_state == S_UPD);
    assign w_wa    = (r_state == S_CLEAR) ? r_clr : r_cl.idx;
    assign w_pm_wd = (r_state == S_CLEAR) ? 16'd0 : r_cl.mean;
    assign w_cs_wd = (r_state == S_CLEAR || r_cl.last_pulse) ? 44'd0 : w_csnew;

    assign w_ai = s_axis_tdata[28] ? 16'(-s_axis_tdata[28:13]) : s_axis_tdata[28:13];
    assign w_aq = s_axis_tdata[44] ? 16'(-s_axis_tdata[44:29]) : s_axis_tdata[44:29];
    assign w_sq = {16'd0, r_i} * {16'd0, r_i} + {16'd0, r_q} * {16'd0, r_q};
    assign w_mag   = r_root;
    assign w_gs    = {1'b0, r_gsum} + {9'd0, w_mag[15:0]};
    assign w_prod  = {16'd0, r_cl.mean} * {16'd0, r_pm_rd};
    assign w_csum  = {1'b0, r_cs_rd} + {13'd0, w_prod};
    assign w_csnew = r_cl.add_prod ? (w_csum[44] ? CORR_MAX : w_csum[43:0]) : r_cs_rd;
    assign w_t     = r_step + {13'd0, r_frac};
    assign w_pcn   = (r_pc[r_ch] >= w_frame) ? 10'd1 : r_pc[r_ch] + 10'd1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_gsum <= '0; r_fill <= '0; r_quota <= '0; r_frac <= '0;
            r_step <= '0; r_cur <= '0;
            for (int c = 0; c < CHANNELS; c++) r_pc[c] <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_ch <= s_axis_tuser[0];
                        r_i  <= w_ai;
                        r_q  <= w_aq;
                        if (s_axis_tuser[1]) begin
                            r_dnum   <= {15'd0, s_axis_tdata[12:0], 16'd0};
                            r_dden   <= {19'd0, w_gates};
                            r_dstart <= 1'b1;
                            r_cur <= '0; r_gsum <= '0; r_fill <= '0;
                            r_state <= S_STEP;
                        end else if (r_pc[s_axis_tuser[0]] == 10'd0 || r_cur >= w_gates) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SQRT;
                            r_it <= 5'd15; r_root <= '0; r_rad <= '0;
                        end
                    end
                end
                S_STEP: begin
                    if (w_ddone) begin
                        r_step  <= w_dquo[28:0];
                        r_quota <= w_dquo[28:16];
                        r_frac  <= w_dquo[15:0];
                        r_pc[r_ch] <= w_pcn;
                        r_state <= S_SQRT;
                        r_it <= 5'd15; r_root <= '0; r_rad <= '0;
                    end
                end
                S_SQRT: begin
                    // bitwise root: r_rad holds the square, set bits high to low
                    if (r_it == 5'd15 && r_rad == 32'd0) r_rad <= w_sq;
                    begin
                        logic [31:0] tr;
                        tr = r_root | (32'd1 << r_it);
                        if (r_it == 5'd15 && r_rad == 32'd0) begin
                            if (tr * tr <= w_sq) r_root <= tr;
                        end else if (tr * tr <= r_rad) r_root <= tr;
                    end
                    r_it <= r_it - 5'd1;
                    if (r_it == 5'd0) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cl.idx  <= {r_ch, r_cur[GATE_W-1:0]};
                    r_cl.ch   <= r_ch;
                    r_cl.gate <= r_cur[8:0];
                    r_cl.add_prod   <= r_pc[r_ch] >= 10'd2;
                    r_cl.last_pulse <= r_pc[r_ch] >= w_frame;
                    if (r_quota == 13'd0) begin
                        r_cl.mean <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_gsum <= w_gs[24] ? SUM_MAX : w_gs[23:0];
                        r_fill <= r_fill + 13'd1;
                        if (r_fill + 13'd1 < r_quota) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_dnum   <= {20'd0, (w_gs[24] ? SUM_MAX : w_gs[23:0])};
                            r_dden   <= {16'd0, r_fill + 13'd1};
                            r_dstart <= 1'b1;
                            r_state  <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_ddone) begin
                        r_cl.mean <= w_dquo[15:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_cur   <= r_cur + 10'd1;
                    r_quota <= w_t[28:16];
                    r_frac  <= w_t[15:0];
                    r_gsum  <= '0;
                    r_fill  <= '0;
                    r_state <= r_cl.last_pulse ? S_FRM : S_OUT;
                    if (r_cl.last_pulse) begin
                        r_dnum   <= w_csnew;
                        r_dden   <= {19'd0, w_frame};
                        r_dstart <= 1'b1;
                    end
                end
                S_FRM: begin
                    // quotient stays on the divider output until the next start
                    if (w_ddone) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {5'd0, (r_cl.last_pulse ? w_dquo[33:0] : 34'd0),
                                     r_cl.mean, r_cl.gate};
                        r_ouser  <= {r_cl.last_pulse, r_cl.ch};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !s_axis_tready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid) else $error("result dropped");
    a_write_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> w_we) else $error("no write back");
endmodule

@@ rtl/rrga_divider.sv @@
// ----------------------------------------------------------------------------
// rrga_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rrga_divider
    import rrga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [43:0] i_num,
    input  logic [28:0] i_den,
    output logic        o_done,
    output logic [43:0] o_quo
);
    logic [43:0] r_quo;
    logic [29:0] r_rem;
    logic [28:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [29:0] w_sh;
    logic [30:0] w_diff;

    assign w_sh   = {r_rem[28:0], r_quo[43]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd44;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[30]) begin
                    r_rem <= w_diff[29:0];
                    r_quo <= {r_quo[42:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[42:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != 6'd0 |-> r_cnt <= 6'd44) else $error("count range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
endmodule
